[rtl/rfwb_pkg.sv]
package rfwb_pkg;

    // Default queue depth; the top level hands it down as a parameter.
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int OPCODE_W   = 2;
    localparam int TAG_W      = 16;
    localparam int SEQ_W      = 32;
    localparam int CHUNK_W    = 16;
    localparam int ENTRY_W    = TAG_W + SEQ_W + CHUNK_W;
    localparam int UPPER_WM_W = 7;
    localparam int LOWER_WM_W = 6;
    localparam int CFG_DATA_W = UPPER_WM_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [UPPER_WM_W-1:0] UPPER_WM_RESET = UPPER_WM_W'(48);
    localparam logic [LOWER_WM_W-1:0] LOWER_WM_RESET = LOWER_WM_W'(16);

    // Opcodes. Code 3 is ignored: status only, no state change.
    localparam logic [OPCODE_W-1:0] OP_REFUSED = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SENT    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_WM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_WM = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [TAG_W-1:0]    item_tag;
        logic [SEQ_W-1:0]    item_sequence;
        logic [CHUNK_W-1:0]  item_chunk;
    } req_payload_t;

    typedef struct packed {
        logic               out_valid;
        logic [TAG_W-1:0]   out_tag;
        logic [SEQ_W-1:0]   out_sequence;
        logic [CHUNK_W-1:0] out_chunk;
        logic               apply_pressure;
        logic               release_pressure;
        logic               pressure_active;
        logic               queue_empty;
        logic               overflow;
    } rsp_payload_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch the request payload
        logic exec;     // push, pending and pressure update
        logic pop;      // read queue head
        logic form;     // build the response register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_needed;   // valid while in exec
    } dp_sts_t;

endpackage

[rtl/rfwb_req_if.sv]
interface rfwb_req_if;
    import rfwb_pkg::*;

    logic         valid;
    logic         ready;
    req_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/rfwb_rsp_if.sv]
interface rfwb_rsp_if;
    import rfwb_pkg::*;

    logic         valid;
    logic         ready;
    rsp_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/retry_fifo_with_watermark_backpressure_core.sv]
// Retry queue with high/low watermark backpressure.
//
// Channels: req (sink) carries one command transaction: opcode, item_tag,
// item_sequence, item_chunk. rsp (source) returns exactly one result
// transaction per command: the item handed back (if any) plus pressure and
// queue status. cfg_we/cfg_index/cfg_wdata write the upper (index 0) and lower
// (index 1) watermarks; write them only while no command is in flight.
//
// Sequencing: rsp.valid rises once the command has passed the exec state, the
// pop state (only when the head is read: the queue RAM has one registered read
// port, so the pop takes its own state) and the form state. The controller holds
// one command at a time: req.ready is high only while idle, so a new command is
// taken only after rsp has taken the result of the last one.
//
// Reset: queue empty, nothing pending, backpressure off, watermarks 48/16.
// The queue RAM is not cleared; only entries written since reset are read.
// Receiver stall: the result is held steady in the output register and
// req.ready stays low until rsp takes the transaction.
module retry_fifo_with_watermark_backpressure_core #(
    parameter int QUEUE_DEPTH = rfwb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rfwb_req_if.sink                        req,
    rfwb_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [rfwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfwb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rfwb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer: idle -> exec -> (pop) -> form -> result.
    rfwb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Queue RAM, pointers, pending item, pressure flag, watermarks, result reg.
    rfwb_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_payload (req.payload),
        .rsp_payload (rsp.payload),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

endmodule

[rtl/rfwb_ctrl.sv]
module rfwb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  rfwb_pkg::dp_sts_t sts,
    output rfwb_pkg::dp_cmd_t cmd
);
    import rfwb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_POP    = 5'b00100,
        ST_FORM   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.pop_needed ? ST_POP : ST_FORM;
            end
            ST_POP:
            begin
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = (state_reg == ST_RESULT);
    assign cmd.accept = (state_reg == ST_IDLE) && req_valid;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign cmd.pop    = (state_reg == ST_POP);
    assign cmd.form   = (state_reg == ST_FORM);

endmodule

[rtl/rfwb_dp.sv]
module rfwb_dp #(
    parameter int QUEUE_DEPTH = rfwb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rfwb_pkg::dp_cmd_t                   cmd,
    output rfwb_pkg::dp_sts_t                   sts,
    input  rfwb_pkg::req_payload_t              req_payload,
    output rfwb_pkg::rsp_payload_t              rsp_payload,
    input  logic                                cfg_we,
    input  logic [rfwb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfwb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rfwb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > UPPER_WM_W) ? CNT_W : UPPER_WM_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] fifo_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [UPPER_WM_W-1:0] upper_wm_reg;
    logic [LOWER_WM_W-1:0] lower_wm_reg;

    req_payload_t item_reg;
    rsp_payload_t rsp_reg;

    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pending_valid_reg;
    logic [SEQ_W-1:0]   pending_seq_reg;
    logic [CHUNK_W-1:0] pending_chunk_reg;
    logic             pressure_reg;

    // per-transaction flags
    logic hit_reg, pop_hit_reg, applied_reg, released_reg, ovf_reg;

    logic               is_refused, is_sent, is_pop, hit, push, full, applied, released;
    logic [ENTRY_W-1:0] offered;

    assign is_refused = (item_reg.opcode == OP_REFUSED);
    assign is_sent    = (item_reg.opcode == OP_SENT);
    assign is_pop     = (item_reg.opcode == OP_POP);
    assign offered    = {item_reg.item_tag, item_reg.item_sequence, item_reg.item_chunk};
    assign full       = (count_reg == CNT_FULL);

    assign hit = is_refused && pending_valid_reg
              && (item_reg.item_sequence == pending_seq_reg)
              && (item_reg.item_chunk == pending_chunk_reg);

    assign push       = is_refused && !hit && !full;
    assign count_next = push ? count_reg + CNT_W'(1) : count_reg;

    assign applied  = is_refused && !hit && !pressure_reg
                   && (CMP_W'(count_next) >= CMP_W'(upper_wm_reg));
    assign released = is_sent && pressure_reg
                   && (CMP_W'(count_reg) <= CMP_W'(lower_wm_reg));

    // A refused, unmatched offer always leaves the queue non-empty.
    assign sts.pop_needed = (is_refused && !hit && !pending_valid_reg)
                         || ((is_sent || is_pop) && (count_reg != '0));

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Queue storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push)
        begin
            fifo_mem[tail_reg] <= offered;
        end
        if (cmd.pop)
        begin
            rdata_reg <= fifo_mem[head_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_payload;
        end
        if (cmd.form)
        begin
            rsp_reg.out_valid <= hit_reg || pop_hit_reg;
            if (hit_reg)
            begin
                {rsp_reg.out_tag, rsp_reg.out_sequence, rsp_reg.out_chunk} <= offered;
            end
            else if (pop_hit_reg)
            begin
                {rsp_reg.out_tag, rsp_reg.out_sequence, rsp_reg.out_chunk} <= rdata_reg;
            end
            else
            begin
                {rsp_reg.out_tag, rsp_reg.out_sequence, rsp_reg.out_chunk} <= '0;
            end
            rsp_reg.apply_pressure   <= applied_reg;
            rsp_reg.release_pressure <= released_reg;
            rsp_reg.pressure_active  <= pressure_reg;
            rsp_reg.queue_empty      <= (count_reg == '0);
            rsp_reg.overflow         <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_wm_reg      <= UPPER_WM_RESET;
            lower_wm_reg      <= LOWER_WM_RESET;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            pending_valid_reg <= 1'b0;
            pending_seq_reg   <= '0;
            pending_chunk_reg <= '0;
            pressure_reg      <= 1'b0;
            hit_reg           <= 1'b0;
            pop_hit_reg       <= 1'b0;
            applied_reg       <= 1'b0;
            released_reg      <= 1'b0;
            ovf_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_UPPER_WM: upper_wm_reg <= cfg_wdata;
                    CFG_LOWER_WM: lower_wm_reg <= cfg_wdata[LOWER_WM_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.exec)
            begin
                hit_reg      <= hit;
                pop_hit_reg  <= sts.pop_needed;
                applied_reg  <= applied;
                released_reg <= released;
                ovf_reg      <= is_refused && !hit && full;
                if (push)
                begin
                    tail_reg <= ptr_inc(tail_reg);
                end
                count_reg <= count_next;
                if (applied)
                begin
                    pressure_reg <= 1'b1;
                end
                if (released)
                begin
                    pressure_reg <= 1'b0;
                end
                if (is_sent)
                begin
                    pending_valid_reg <= 1'b0;
                    pending_seq_reg   <= '0;
                    pending_chunk_reg <= '0;
                end
            end

            if (cmd.pop)
            begin
                head_reg  <= ptr_inc(head_reg);
                count_reg <= count_reg - CNT_W'(1);
            end

            // popped head becomes the pending item on a refused offer
            if (cmd.form && pop_hit_reg && is_refused)
            begin
                pending_valid_reg <= 1'b1;
                pending_seq_reg   <= rdata_reg[CHUNK_W +: SEQ_W];
                pending_chunk_reg <= rdata_reg[CHUNK_W-1:0];
            end
        end
    end

    assign rsp_payload = rsp_reg;

endmodule

[test/retry_fifo_with_watermark_backpressure_core_tb.sv]
module retry_fifo_with_watermark_backpressure_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfwb_pkg::*;

    localparam int DEPTH   = QUEUE_DEPTH_DEF;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int PHASES  = 8;
    localparam int RANDOM_PER_PHASE = 212;

    // Opcode 3 has no name in the package; the block ignores it.
    localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rfwb_req_if req_ch();
    rfwb_rsp_if rsp_ch();

    retry_fifo_with_watermark_backpressure_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Retry queue shadow: FIFO of refused items, the one item in flight,
    // and the backpressure flag with its two watermarks.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]    slot_mem [DEPTH];
    logic [PTR_W-1:0]      rd_ptr = '0;
    logic [PTR_W-1:0]      wr_ptr = '0;
    logic [FILL_W-1:0]     fill_level = '0;
    logic                  inflight_valid = 1'b0;
    logic [SEQ_W-1:0]      inflight_seq = '0;
    logic [CHUNK_W-1:0]    inflight_chunk = '0;
    logic                  bp_on = 1'b0;
    logic [UPPER_WM_W-1:0] wm_high = UPPER_WM_RESET;
    logic [LOWER_WM_W-1:0] wm_low = LOWER_WM_RESET;

    // Transactions waiting to be offered, and results still owed by the block.
    req_payload_t command_q[$];
    rsp_payload_t outcome_q[$];
    // Last few refused items, re-offered so the in-flight match gets hit.
    req_payload_t recent_offers[$];

    int  mismatches = 0;
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;

    // Sender and receiver pacing state.
    int   send_gap = 0;
    int   send_run = 0;
    logic drain_hold = 1'b0;
    int   recv_stall = 0;
    int   recv_run = 0;

    function automatic logic [ENTRY_W-1:0] take_head();
        logic [ENTRY_W-1:0] e;
        e = slot_mem[rd_ptr];
        rd_ptr = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        fill_level = fill_level - FILL_W'(1);
        return e;
    endfunction

    // One command through the retry queue; returns the status it reports.
    function automatic rsp_payload_t retry_queue_update(req_payload_t cmd);
        rsp_payload_t r;
        logic [ENTRY_W-1:0] ent;
        logic hit;
        r = '0;
        ent = '0;
        case (cmd.opcode)
            OP_REFUSED:
            begin
                hit = inflight_valid && cmd.item_sequence == inflight_seq
                      && cmd.item_chunk == inflight_chunk;
                if (hit)
                begin
                    // offered item is the one in flight: hand it straight back
                    r.out_valid = 1'b1;
                    ent = {cmd.item_tag, cmd.item_sequence, cmd.item_chunk};
                end
                else
                begin
                    if (fill_level == FILL_W'(DEPTH))
                        r.overflow = 1'b1;
                    else
                    begin
                        slot_mem[wr_ptr] = {cmd.item_tag, cmd.item_sequence, cmd.item_chunk};
                        wr_ptr = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
                        fill_level = fill_level + FILL_W'(1);
                    end
                    if (!bp_on && fill_level >= wm_high)
                    begin
                        bp_on = 1'b1;
                        r.apply_pressure = 1'b1;
                    end
                    if (!inflight_valid && fill_level != 0)
                    begin
                        ent = take_head();
                        r.out_valid = 1'b1;
                        inflight_valid = 1'b1;
                        inflight_seq = ent[CHUNK_W +: SEQ_W];
                        inflight_chunk = ent[CHUNK_W-1:0];
                    end
                end
            end
            OP_SENT:
            begin
                inflight_valid = 1'b0;
                inflight_seq = '0;
                inflight_chunk = '0;
                if (bp_on && fill_level <= FILL_W'(wm_low))
                begin
                    bp_on = 1'b0;
                    r.release_pressure = 1'b1;
                end
                if (fill_level != 0)
                begin
                    ent = take_head();
                    r.out_valid = 1'b1;
                end
            end
            OP_POP:
            begin
                if (fill_level != 0)
                begin
                    ent = take_head();
                    r.out_valid = 1'b1;
                end
            end
            default:
                ;
        endcase
        if (r.out_valid)
        begin
            r.out_tag = ent[ENTRY_W-1 -: TAG_W];
            r.out_sequence = ent[CHUNK_W +: SEQ_W];
            r.out_chunk = ent[CHUNK_W-1:0];
        end
        r.pressure_active = bp_on;
        r.queue_empty = (fill_level == 0);
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    function automatic void compare_outcome(rsp_payload_t want, rsp_payload_t got);
        check_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
        check_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
        check_field("out_sequence", want.out_sequence, got.out_sequence);
        check_field("out_chunk", 32'(want.out_chunk), 32'(got.out_chunk));
        check_field("apply_pressure", 32'(want.apply_pressure), 32'(got.apply_pressure));
        check_field("release_pressure", 32'(want.release_pressure),
                    32'(got.release_pressure));
        check_field("pressure_active", 32'(want.pressure_active), 32'(got.pressure_active));
        check_field("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
        check_field("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction

    // Idle draw shared by both sides: mostly a random idle gap, with occasional
    // stretches of back-to-back transactions.
    function automatic int draw_wait(ref int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            run_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver. Changes only at the falling edge; the accept flag
    // comes from the monitor's sample at the previous rising edge. Each
    // signal gets exactly one nonblocking update per edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        req_payload_t nxt_cmd;
        logic         nxt_valid;
        if (rst_n)
        begin
            nxt_valid = req_ch.valid;
            nxt_cmd = req_ch.payload;
            if (req_taken)
            begin
                nxt_valid = 1'b0;
                send_gap = draw_wait(send_run);
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 199) == 0)
                    drain_hold = 1'b1;
            end
            if (!nxt_valid)
            begin
                if (drain_hold && outcome_q.size() == 0)
                    drain_hold = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (!drain_hold && command_q.size() != 0)
                begin
                    nxt_cmd = command_q[0];
                    command_q.delete(0);
                    nxt_valid = 1'b1;
                end
            end
            req_ch.valid <= nxt_valid;
            req_ch.payload <= nxt_cmd;
        end
    end

    // Result receiver: a fresh stall is drawn after every taken result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
                recv_stall = draw_wait(recv_run);
            else if (recv_stall > 0)
                recv_stall--;
            rsp_ch.ready <= (recv_stall == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Accepted commands
    // go through the shadow queue; taken results are checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_payload_t want_rsp;
        if (rst_n)
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            rsp_taken <= rsp_ch.valid && rsp_ch.ready;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_UPPER_WM: wm_high = cfg_wdata[UPPER_WM_W-1:0];
                    CFG_LOWER_WM: wm_low = cfg_wdata[LOWER_WM_W-1:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                outcome_q.push_back(retry_queue_update(req_ch.payload));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $error("result transaction with no command outstanding");
                end
                else
                begin
                    want_rsp = outcome_q[0];
                    outcome_q.delete(0);
                    compare_outcome(want_rsp, rsp_ch.payload);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_cmd(input req_payload_t c);
        command_q.push_back(c);
        if (c.opcode == OP_REFUSED)
        begin
            recent_offers.push_back(c);
            if (recent_offers.size() > 16)
                recent_offers.delete(0);
        end
    endtask

    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [TAG_W-1:0] tag,
                             input logic [SEQ_W-1:0] seq, input logic [CHUNK_W-1:0] chunk);
        req_payload_t c;
        c.opcode = op;
        c.item_tag = tag;
        c.item_sequence = seq;
        c.item_chunk = chunk;
        add_cmd(c);
    endtask

    // A refused-send offer: a retry of a recent item, a corner-value item,
    // or a fully random one.
    function automatic req_payload_t make_offer();
        logic [SEQ_W-1:0]   seq_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};
        logic [CHUNK_W-1:0] chunk_pool[4] = '{16'h0, 16'hFFFF, 16'h1, 16'h8000};
        req_payload_t c;
        c.opcode = OP_REFUSED;
        c.item_sequence = $urandom;
        c.item_chunk = 16'($urandom);
        if (recent_offers.size() != 0 && $urandom_range(0, 4) == 0)
            c = recent_offers[$urandom_range(0, recent_offers.size() - 1)];
        else if ($urandom_range(0, 2) == 0)
        begin
            c.item_sequence = seq_pool[$urandom_range(0, 3)];
            c.item_chunk = chunk_pool[$urandom_range(0, 3)];
        end
        c.item_tag = 16'($urandom);
        return c;
    endfunction

    // Random traffic in fill and drain segments so the queue swings
    // across both watermarks and now and then runs full.
    task automatic run_random(input int n);
        int left;
        int seg;
        int roll;
        logic filling;
        req_payload_t c;
        left = n;
        while (left > 0)
        begin
            filling = 1'($urandom_range(0, 1));
            seg = $urandom_range(8, 70);
            if (seg > left)
                seg = left;
            repeat (seg)
            begin
                roll = $urandom_range(0, 99);
                c = make_offer();
                if (filling)
                    c.opcode = (roll < 82) ? OP_REFUSED : (roll < 90) ? OP_SENT :
                               (roll < 97) ? OP_POP : OP_IGNORED;
                else
                    c.opcode = (roll < 15) ? OP_REFUSED : (roll < 55) ? OP_SENT :
                               (roll < 95) ? OP_POP : OP_IGNORED;
                add_cmd(c);
            end
            left -= seg;
        end
    endtask

    // Block is idle once nothing is queued, nothing offered, nothing owed.
    task automatic wait_idle();
        while (command_q.size() != 0 || req_ch.valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_watermark(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Phase 0 keeps the reset watermarks; the rest cover the extremes,
        // out-of-range values, inverted pairs, and bit 6 on the lower index.
        int upper_set[PHASES] = '{48, 64, 1, 8, 0, 127, 20, 33};
        int lower_set[PHASES] = '{16, 0, 0, 4, 63, 127, 30, 32};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_UPPER_WM;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero offer with nothing in flight must not match the
        // cleared in-flight registers; it is pushed and popped straight back.
        queue_cmd(OP_REFUSED, 16'h0000, 32'h0, 16'h0);
        // same sequence/chunk again now matches the in-flight item
        queue_cmd(OP_REFUSED, 16'hFFFF, 32'h0, 16'h0);
        queue_cmd(OP_REFUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_cmd(OP_IGNORED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_cmd(OP_POP, 16'h0, 32'h0, 16'h0);
        queue_cmd(OP_POP, 16'h0, 32'h0, 16'h0);          // pop from empty queue
        queue_cmd(OP_SENT, 16'h0, 32'h0, 16'h0);
        queue_cmd(OP_SENT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_cmd(OP_REFUSED, 16'hAAAA, 32'h5, 16'h7);
        queue_cmd(OP_REFUSED, 16'h5555, 32'h5, 16'h8);   // chunk differs
        queue_cmd(OP_REFUSED, 16'h1234, 32'h6, 16'h7);   // sequence differs
        queue_cmd(OP_REFUSED, 16'h4321, 32'h5, 16'h7);   // full match
        queue_cmd(OP_SENT, 16'h0, 32'h0, 16'h0);
        queue_cmd(OP_POP, 16'h0, 32'h0, 16'h0);
        queue_cmd(OP_IGNORED, 16'h0, 32'h0, 16'h0);

        // Fill past the top: pressure rises at the upper watermark, the last
        // pushes overflow, and the in-flight item still matches while full.
        for (int i = 0; i < 68; i++)
            queue_cmd(OP_REFUSED, ~16'(i), 32'hC000_0000 + i, 16'(i));
        queue_cmd(OP_REFUSED, 16'hBEEF, 32'hC000_0000, 16'h0);
        // Drain to empty: pressure drops at the lower watermark.
        for (int i = 0; i < 70; i++)
            queue_cmd((i % 2 == 0) ? OP_SENT : OP_POP, 16'(i), 32'(i), 16'(i));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_idle();
                set_watermark(CFG_UPPER_WM, upper_set[p]);
                set_watermark(CFG_LOWER_WM, lower_set[p]);
                @(posedge clk);
            end
            run_random(RANDOM_PER_PHASE);
        end

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
